### rtl/core/signed_int_to_decimal_ascii_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal ASCII converter
// Clocked concurrent checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// check that cond holds at every clock edge
`define SITOA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// check that cons holds whenever ante holds
`define SITOA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Types and constants shared by the decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int REMAIN_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clr;
        logic bit_shift;
        logic digit_shift;
    } cell_ctrl_t;

endpackage

### rtl/core/sitoa_bcd_cell.sv
// ----------------------------------------------------------------------------
// sitoa_bcd_cell
// One BCD digit of the shift-and-add-3 chain; also shifts whole digits up.
// ----------------------------------------------------------------------------
module sitoa_bcd_cell (
    input  logic                   aclk,
    input  sitoa_pkg::cell_ctrl_t  ctrl,
    input  logic                   bit_in,
    input  logic [3:0]             digit_in,
    output logic                   bit_out,
    output logic [3:0]             digit
);
    import sitoa_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    assign adj     = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clr) begin
            digit_next = 4'd0;
        end else if (ctrl.bit_shift) begin
            digit_next = {adj[2:0], bit_in};
        end else if (ctrl.digit_shift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

### rtl/core/signed_int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII, one character per output request.
// ----------------------------------------------------------------------------
// Each input request is converted by a chain of ten BCD digit cells that take
// the magnitude one bit per cycle, then leading zeros are shifted out of the
// top cell and the characters leave from the top cell, one per cycle while
// the output is not stalled, behind an output register. An item passes
// through accept, conversion, zero skipping, the sign when negative, and the
// digits; s_tready is high only between items. The last character of a run
// carries m_tlast.
module signed_int_to_decimal_ascii_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] character
    output logic        m_tlast
);
    import sitoa_pkg::*;

`include "signed_int_to_decimal_ascii_core_assert.svh"

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [REMAIN_W-1:0]   remain_reg, remain_next;
    logic [VALUE_W-1:0]    mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [7:0]            m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;

    cell_ctrl_t            ctrl;
    logic [3:0]            digit [NUM_DIGITS];
    logic                  carry [NUM_DIGITS];
    logic [3:0]            top;
    logic                  out_free;
    logic                  load_out;
    logic [7:0]            char_out;
    logic                  last_out;
    logic                  char_ok;

    assign top      = digit[NUM_DIGITS-1];
    assign out_free = !m_tvalid_reg || m_tready;

    for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
        if (i == 0) begin : g_first
            sitoa_bcd_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .bit_in   (mag_reg[VALUE_W-1]),
                .digit_in (4'd0),
                .bit_out  (carry[i]),
                .digit    (digit[i])
            );
        end else begin : g_rest
            sitoa_bcd_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .bit_in   (carry[i-1]),
                .digit_in (digit[i-1]),
                .bit_out  (carry[i]),
                .digit    (digit[i])
            );
        end
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        remain_next = remain_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    neg_next   = s_tdata[VALUE_W-1];
                    mag_next   = s_tdata[VALUE_W-1] ? (~s_tdata + 32'd1) : s_tdata;
                    cnt_next   = CNT_W'(VALUE_W - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    remain_next = REMAIN_W'(NUM_DIGITS);
                    state_next  = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top == 4'd0 && remain_reg > REMAIN_W'(1)) begin
                    remain_next = remain_reg - 1'b1;
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == REMAIN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl     = '0;
        s_tready = 1'b0;
        load_out = 1'b0;
        char_out = CHAR_ZERO + {4'd0, top};
        last_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ctrl.clr = s_tvalid;
            end
            ST_CONV: begin
                ctrl.bit_shift = 1'b1;
            end
            ST_SKIP: begin
                ctrl.digit_shift = (top == 4'd0) && (remain_reg > REMAIN_W'(1));
            end
            ST_SIGN: begin
                load_out = out_free;
                char_out = CHAR_MINUS;
            end
            ST_EMIT: begin
                load_out         = out_free;
                last_out         = (remain_reg == REMAIN_W'(1));
                ctrl.digit_shift = out_free;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = char_out;
            m_tlast_next  = last_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cnt_reg     <= cnt_next;
        remain_reg  <= remain_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign char_ok = (m_tdata == CHAR_MINUS) || (m_tdata >= CHAR_ZERO && m_tdata <= CHAR_NINE);

    `SITOA_ASSERT_IMPL(a_no_overflow, state_reg == ST_CONV, !carry[NUM_DIGITS-1], "BCD overflow")
    `SITOA_ASSERT_IMPL(a_emit_count, state_reg == ST_EMIT, remain_reg != '0, "emit past end")
    `SITOA_ASSERT_IMPL(a_sign_neg, state_reg == ST_SIGN, neg_reg, "sign on positive")
    `SITOA_ASSERT_IMPL(a_char_range, m_tvalid, char_ok, "bad output character")

endmodule

### test/signed_int_to_decimal_ascii_core_checker.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_checker
// Watches both channels of the decimal ASCII converter, renders every accepted
// input value into its expected characters and compares each output request
// with the oldest expected character, field by field.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] character
    input  logic        m_tlast,
    output int unsigned chars_pending,
    output int unsigned mismatch_count
);
    import sitoa_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } ascii_char_t;

    ascii_char_t expected_chars[$];
    int unsigned mismatches = 0;

    task automatic render_decimal(input logic [31:0] value);
        logic [7:0]  rev [NUM_DIGITS];
        logic [31:0] mag;
        int          ndig;
        ascii_char_t c;
        mag  = value[31] ? (~value + 32'd1) : value;
        ndig = 0;
        do begin
            rev[ndig] = CHAR_ZERO + 8'(mag % 32'd10);
            mag       = mag / 32'd10;
            ndig++;
        end while (mag != 0 && ndig < NUM_DIGITS);
        if (value[31]) begin
            c.ch   = CHAR_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        while (ndig > 0) begin
            ndig--;
            c.ch   = rev[ndig];
            c.last = (ndig == 0);
            expected_chars.push_back(c);
        end
    endtask

    always @(posedge aclk) begin
        ascii_char_t exp_c;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                render_decimal(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    exp_c = expected_chars.pop_front();
                    if (m_tdata !== exp_c.ch) begin
                        mismatches++;
                        $display("%0t: character mismatch: expected %h, actual %h",
                                 $time, exp_c.ch, m_tdata);
                    end
                    if (m_tlast !== exp_c.last) begin
                        mismatches++;
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, exp_c.last, m_tlast);
                    end
                end
            end
        end
        chars_pending  <= expected_chars.size();
        mismatch_count <= mismatches;
    end

endmodule

### test/signed_int_to_decimal_ascii_core_tb.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_tb
// Feeds the decimal ASCII converter with directed edge values, then random
// values of every length and sign, under random gaps on both channels save one
// gap-free stretch, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_tb;

    import sitoa_pkg::*;

    localparam int RANDOM_ITEMS = 500;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        gaps_on  = 1'b1;

    int unsigned chars_pending;
    int unsigned mismatch_count;

    logic [31:0] directed_values [] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        -32'sd100, 32'd12345, -32'sd67890, 32'd999999999, 32'd1000000000,
        -32'sd999999999, -32'sd1000000000, 32'h7FFFFFFF, 32'h80000001, 32'h80000000,
        32'h55555555, 32'hAAAAAAAA, 32'h00FF00FF
    };

    always #5 aclk = ~aclk;

    signed_int_to_decimal_ascii_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    signed_int_to_decimal_ascii_core_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .chars_pending  (chars_pending),
        .mismatch_count (mismatch_count)
    );

    always @(posedge aclk) begin
        m_tready <= gaps_on ? ($urandom_range(99) >= 23) : 1'b1;
    end

    task automatic send_value(input logic [31:0] value);
        while (gaps_on && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] random_value();
        longint lo;
        longint hi;
        longint mag;
        int     mode;
        int     ndig;
        logic   neg;
        mode = $urandom_range(99);
        neg  = 1'($urandom_range(1));
        if (mode < 60) begin
            ndig = $urandom_range(NUM_DIGITS, 1);
            lo   = 1;
            repeat (ndig - 1) lo = lo * 10;
            hi   = lo * 10 - 1;
            if (hi > 64'd2147483647)
                hi = 64'd2147483647;
            if (ndig == 1)
                lo = 0;
            mag = lo + longint'($urandom) % (hi - lo + 1);
        end else if (mode < 90) begin
            return $urandom;
        end else begin
            mag = 1;
            repeat ($urandom_range(NUM_DIGITS - 1)) mag = mag * 10;
            mag = mag + $urandom_range(2) - 1;
            if ($urandom_range(9) == 0)
                mag = neg ? 64'd2147483648 : 64'd2147483647;
        end
        return neg ? 32'(-mag) : 32'(mag);
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_values[i])
            send_value(directed_values[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gaps_on <= !(n >= 150 && n < 250);
            send_value(random_value());
        end
        s_tvalid <= 1'b0;
        gaps_on  <= 1'b1;
        @(posedge aclk);
        while (chars_pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && chars_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
